// File: design/julia_escape_time_pixel_defines.svh
// Assertion macros for the Julia escape-time pixel engine.
// Used by the top level only; no other dependencies.
`ifndef JULIA_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define JULIA_ESCAPE_TIME_PIXEL_DEFINES_SVH
`ifndef SYNTHESIS
`define JETP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define JETP_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define JETP_ASSERT_IMP(label, clk, rstn, ante, cons)
`define JETP_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// File: design/jetp_pkg.sv
// Shared types, constants and helpers of the Julia escape-time pixel engine.
// No dependencies.
package jetp_pkg;

    localparam int MAX_ITER   = 24;
    localparam int FRAC_BITS  = 20;
    localparam int W          = 24;
    localparam int STEP_W     = 21;
    localparam int PIX_W      = 10;
    localparam int CNT_OUT_W  = 5;
    localparam int BRIGHT_W   = 8;
    localparam int CNT_W      = $clog2(MAX_ITER + 1);
    localparam int PROD_W     = 2 * W;
    localparam int SH_W       = PROD_W - FRAC_BITS;
    localparam int CELL_SUM_W = (SH_W + 3 > FRAC_BITS + 4) ? SH_W + 3 : FRAC_BITS + 4;
    localparam int MAP_SUM_W  = PIX_W + STEP_W + 2;
    localparam int SAT_W      = (CELL_SUM_W > MAP_SUM_W) ? CELL_SUM_W : MAP_SUM_W;
    localparam int CFG_IDX_W  = 3;
    localparam int BRIGHT_SH  = 24;
    localparam longint BRIGHT_MUL = ((longint'(1) <<< BRIGHT_SH) + MAX_ITER - 1) / MAX_ITER;

    localparam logic [CFG_IDX_W-1:0] REG_C_REAL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_C_IMAG     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_EDGE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_EDGE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP = 3'd4;

    localparam logic signed [W-1:0] RST_LEFT_EDGE  = -24'sd2621440;
    localparam logic signed [W-1:0] RST_TOP_EDGE   = 24'sd1572864;
    localparam logic [STEP_W-1:0]   RST_PIXEL_STEP = 21'd6554;

    localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'((64'sd1 <<< (W - 1)) - 1);
    localparam logic signed [SAT_W-1:0] SAT_MIN = -SAT_W'(64'sd1 <<< (W - 1));
    localparam logic signed [CELL_SUM_W-1:0] ESC_LIMIT = CELL_SUM_W'(64'sd4 <<< FRAC_BITS);

    typedef struct packed {
        logic [PIX_W-1:0] column;
        logic [PIX_W-1:0] row;
    } jetp_in_t;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] escape_count;
        logic [BRIGHT_W-1:0]  brightness;
    } jetp_out_t;

    typedef struct packed {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic [CNT_W-1:0]    count;
        logic                done;
    } jetp_z_t;

    function automatic logic signed [W-1:0] sat_w(input logic signed [SAT_W-1:0] v);
        logic signed [W-1:0] r;
        if (v > SAT_MAX) r = SAT_MAX[W-1:0];
        else if (v < SAT_MIN) r = SAT_MIN[W-1:0];
        else r = v[W-1:0];
        return r;
    endfunction

    // reciprocal multiply, exact for counts up to MAX_ITER
    function automatic logic [BRIGHT_W-1:0] bright(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+8:0] p;
        logic [CNT_W+8+BRIGHT_SH:0] q;
        p = (CNT_W + 9)'(cnt) * (CNT_W + 9)'(255);
        q = (CNT_W + 9 + BRIGHT_SH)'(p) * (CNT_W + 9 + BRIGHT_SH)'(BRIGHT_MUL);
        return BRIGHT_W'(q >> BRIGHT_SH);
    endfunction

endpackage

// File: design/jetp_map.sv
// Entry stage: maps pixel column/row to the starting point of the orbit.
// Depends on jetp_pkg.
module jetp_map (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  jetp_pkg::jetp_in_t            pix,
    input  logic signed [jetp_pkg::W-1:0] left_edge,
    input  logic signed [jetp_pkg::W-1:0] top_edge,
    input  logic [jetp_pkg::STEP_W-1:0]   pixel_step,
    output logic                          out_valid,
    output jetp_pkg::jetp_z_t             z_out
);
    import jetp_pkg::*;

    logic [PIX_W+STEP_W-1:0] col_off, row_off;
    logic signed [MAP_SUM_W-1:0] x_full, y_full;
    logic valid_reg;
    jetp_z_t z_reg;

    assign col_off = (PIX_W + STEP_W)'(pix.column) * (PIX_W + STEP_W)'(pixel_step);
    assign row_off = (PIX_W + STEP_W)'(pix.row) * (PIX_W + STEP_W)'(pixel_step);
    assign x_full  = MAP_SUM_W'(left_edge) + $signed(MAP_SUM_W'(col_off));
    assign y_full  = MAP_SUM_W'(top_edge) - $signed(MAP_SUM_W'(row_off));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            z_reg.x     <= sat_w(SAT_W'(x_full));
            z_reg.y     <= sat_w(SAT_W'(y_full));
            z_reg.count <= '0;
            z_reg.done  <= 1'b0;
        end
    end

    assign out_valid = valid_reg;
    assign z_out     = z_reg;
endmodule

// File: design/jetp_cell.sv
// One iteration cell: escape test and z = z^2 + c, registered.
// Depends on jetp_pkg.
module jetp_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  jetp_pkg::jetp_z_t             z_in,
    input  logic signed [jetp_pkg::W-1:0] c_real,
    input  logic signed [jetp_pkg::W-1:0] c_imag,
    output logic                          out_valid,
    output jetp_pkg::jetp_z_t             z_out
);
    import jetp_pkg::*;

    logic signed [PROD_W-1:0] pxx, pyy, pxy;
    logic signed [SH_W-1:0] xx, yy;
    logic signed [SH_W:0] xy2;
    logic signed [CELL_SUM_W-1:0] mag, nx_full, ny_full;
    logic escape;
    logic valid_reg;
    jetp_z_t z_reg;

    assign pxx = PROD_W'(z_in.x) * PROD_W'(z_in.x);
    assign pyy = PROD_W'(z_in.y) * PROD_W'(z_in.y);
    assign pxy = PROD_W'(z_in.x) * PROD_W'(z_in.y);
    assign xx  = pxx[PROD_W-1:FRAC_BITS];
    assign yy  = pyy[PROD_W-1:FRAC_BITS];
    assign xy2 = pxy[PROD_W-1:FRAC_BITS-1];

    assign mag     = CELL_SUM_W'(xx) + CELL_SUM_W'(yy);
    assign escape  = mag > ESC_LIMIT;
    assign nx_full = CELL_SUM_W'(xx) - CELL_SUM_W'(yy) + CELL_SUM_W'(c_real);
    assign ny_full = CELL_SUM_W'(xy2) + CELL_SUM_W'(c_imag);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            if (z_in.done || escape) begin
                z_reg.x     <= z_in.x;
                z_reg.y     <= z_in.y;
                z_reg.count <= z_in.count;
                z_reg.done  <= 1'b1;
            end else begin
                z_reg.x     <= sat_w(SAT_W'(nx_full));
                z_reg.y     <= sat_w(SAT_W'(ny_full));
                z_reg.count <= z_in.count + CNT_W'(1);
                z_reg.done  <= 1'b0;
            end
        end
    end

    assign out_valid = valid_reg;
    assign z_out     = z_reg;
endmodule

// File: design/julia_escape_time_pixel.sv
// Julia set escape-time pixel engine: one transfer in, one result out per pixel.
// From input transfer to result a pixel passes one mapping stage, one cell per iteration in
// a chain, and one output register. A new
// pixel is taken every cycle; the whole chain holds while a result waits on m_ready.
// Depends on jetp_pkg, jetp_map, jetp_cell and julia_escape_time_pixel_defines.svh.
`include "julia_escape_time_pixel_defines.svh"
module julia_escape_time_pixel (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [jetp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jetp_pkg::W-1:0]           cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  jetp_pkg::jetp_in_t               s_payload,
    output logic                             m_valid,
    input  logic                             m_ready,
    output jetp_pkg::jetp_out_t              m_payload
);
    import jetp_pkg::*;

    logic signed [W-1:0] c_real_reg, c_imag_reg, left_edge_reg, top_edge_reg;
    logic [STEP_W-1:0] pixel_step_reg;
    logic en;
    logic    v   [MAX_ITER+1];
    jetp_z_t z   [MAX_ITER+1];
    logic m_valid_reg;
    jetp_out_t m_payload_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_real_reg     <= '0;
            c_imag_reg     <= '0;
            left_edge_reg  <= RST_LEFT_EDGE;
            top_edge_reg   <= RST_TOP_EDGE;
            pixel_step_reg <= RST_PIXEL_STEP;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_C_REAL:     c_real_reg     <= cfg_data;
                REG_C_IMAG:     c_imag_reg     <= cfg_data;
                REG_LEFT_EDGE:  left_edge_reg  <= cfg_data;
                REG_TOP_EDGE:   top_edge_reg   <= cfg_data;
                REG_PIXEL_STEP: pixel_step_reg <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    jetp_map u_map (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_valid),
        .pix        (s_payload),
        .left_edge  (left_edge_reg),
        .top_edge   (top_edge_reg),
        .pixel_step (pixel_step_reg),
        .out_valid  (v[0]),
        .z_out      (z[0])
    );

    for (genvar i = 0; i < MAX_ITER; i++) begin : g_cell
        jetp_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (v[i]),
            .z_in      (z[i]),
            .c_real    (c_real_reg),
            .c_imag    (c_imag_reg),
            .out_valid (v[i+1]),
            .z_out     (z[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v[MAX_ITER];
        end
        if (en) begin
            m_payload_reg.escape_count <= z[MAX_ITER].count[CNT_OUT_W-1:0];
            m_payload_reg.brightness   <= bright(z[MAX_ITER].count);
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    `JETP_ASSERT_IMP(a_ready_rule, aclk, aresetn, 1'b1, s_ready == (!m_valid || m_ready))
    `JETP_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload))
    `JETP_ASSERT_IMP(a_done_count, aclk, aresetn, v[MAX_ITER] && !z[MAX_ITER].done,
                     z[MAX_ITER].count == CNT_W'(MAX_ITER))
endmodule

// File: tb/tb.sv
// Self-checking testbench for julia_escape_time_pixel: escape-time prediction per pixel,
// random handshake idling, config phases. Depends on jetp_pkg and the block's RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import jetp_pkg::*;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [W-1:0] cfg_data = '0;
    logic s_valid = 0;
    logic s_ready;
    jetp_in_t s_payload = '0;
    logic m_valid;
    logic m_ready = 0;
    jetp_out_t m_payload;

    julia_escape_time_pixel uut (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    longint cr, ci, le, te, ps;
    jetp_in_t pixel_q[$];
    jetp_out_t shade_q[$];
    int errors = 0;
    int cycles = 0;
    bit no_idle = 0;
    int hold_left = 0;

    function automatic longint clamp24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint fdown(longint v);
        return v >>> FRAC_BITS;
    endfunction

    function automatic jetp_out_t shade_of(jetp_in_t p);
        jetp_out_t r;
        longint x, y, xx, yy, nx;
        int n;
        x = clamp24(le + longint'(p.column) * ps);
        y = clamp24(te - longint'(p.row) * ps);
        n = MAX_ITER;
        for (int i = 0; i < MAX_ITER; i++) begin
            xx = fdown(x * x);
            yy = fdown(y * y);
            if (xx + yy > (longint'(4) << FRAC_BITS)) begin
                n = i;
                break;
            end
            nx = clamp24(xx - yy + cr);
            y = clamp24(fdown(x * y * 2) + ci);
            x = nx;
        end
        r.escape_count = CNT_OUT_W'(n);
        r.brightness = BRIGHT_W'((n * 255) / MAX_ITER);
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                shade_q.push_back(shade_of(s_payload));
            end
            if (!(s_valid && !s_ready)) begin
                if (pixel_q.size() > 0 && (no_idle || $urandom_range(99) >= 35)) begin
                    s_payload <= pixel_q.pop_front();
                    s_valid <= 1;
                end else begin
                    s_valid <= 0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (shade_q.size() == 0) begin
                    report("unexpected transfer", 0, 0);
                end else begin
                    jetp_out_t e;
                    e = shade_q.pop_front();
                    if (m_payload.escape_count !== e.escape_count)
                        report("escape_count", m_payload.escape_count, e.escape_count);
                    if (m_payload.brightness !== e.brightness)
                        report("brightness", m_payload.brightness, e.brightness);
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 0;
            end else begin
                m_ready <= no_idle || $urandom_range(99) >= 35;
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > 3000000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint v);
        @(posedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= W'(v);
        case (idx)
            REG_C_REAL: cr = longint'(signed'(W'(v)));
            REG_C_IMAG: ci = longint'(signed'(W'(v)));
            REG_LEFT_EDGE: le = longint'(signed'(W'(v)));
            REG_TOP_EDGE: te = longint'(signed'(W'(v)));
            default: ps = longint'(STEP_W'(v));
        endcase
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    task automatic drain();
        while (pixel_q.size() > 0 || s_valid || shade_q.size() > 0) @(posedge aclk);
        repeat (MAX_ITER + 10) @(posedge aclk);
    endtask

    task automatic add_pixel(int c, int r);
        jetp_in_t p;
        p.column = PIX_W'(c);
        p.row = PIX_W'(r);
        pixel_q.push_back(p);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) add_pixel($urandom_range(1023), $urandom_range(1023));
    endtask

    task automatic random_regs();
        write_reg(REG_C_REAL, $urandom_range(2000000) - 1000000);
        write_reg(REG_C_IMAG, $urandom_range(2000000) - 1000000);
        write_reg(REG_LEFT_EDGE, -2621440 + $urandom_range(1048576) - 524288);
        write_reg(REG_TOP_EDGE, 1572864 + $urandom_range(1048576) - 524288);
        write_reg(REG_PIXEL_STEP, $urandom_range(1, 8000));
    endtask

    initial begin
        cr = 0; ci = 0; le = RST_LEFT_EDGE; te = RST_TOP_EDGE; ps = RST_PIXEL_STEP;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        // directed: reset view, field extremes
        add_pixel(0, 0); add_pixel(1023, 1023); add_pixel(0, 1023); add_pixel(1023, 0);
        add_pixel(400, 240); add_pixel(341, 682); add_pixel(512, 512);
        drain();
        // zero step, saturation at extremes, all-zero point never escapes
        write_reg(REG_PIXEL_STEP, 0);
        write_reg(REG_LEFT_EDGE, 0);
        write_reg(REG_TOP_EDGE, 0);
        add_pixel(1023, 1023); add_pixel(5, 9);
        drain();
        write_reg(REG_PIXEL_STEP, 1048576);
        write_reg(REG_LEFT_EDGE, 8388607);
        write_reg(REG_TOP_EDGE, -8388608);
        write_reg(REG_C_REAL, 8388607);
        write_reg(REG_C_IMAG, -8388608);
        add_pixel(0, 0); add_pixel(1023, 1023); add_pixel(1, 1);
        drain();
        write_reg(REG_LEFT_EDGE, -8388608);
        write_reg(REG_TOP_EDGE, 8388607);
        write_reg(REG_C_REAL, -8388608);
        write_reg(REG_C_IMAG, 8388607);
        write_reg(REG_PIXEL_STEP, 1);
        add_pixel(0, 0); add_pixel(1023, 1023);
        drain();
        // near-boundary constant, classic view
        write_reg(REG_C_REAL, -838861);
        write_reg(REG_C_IMAG, 163578);
        write_reg(REG_LEFT_EDGE, RST_LEFT_EDGE);
        write_reg(REG_TOP_EDGE, RST_TOP_EDGE);
        write_reg(REG_PIXEL_STEP, RST_PIXEL_STEP);
        random_phase(250);
        // long receiver hold-off while the sender keeps offering
        hold_left = 200;
        drain();
        random_regs();
        no_idle = 1;
        random_phase(250);
        drain();
        no_idle = 0;
        random_regs();
        random_phase(150);
        drain();
        write_reg(REG_PIXEL_STEP, $urandom_range(1, 1048576));
        random_phase(100);
        drain();
        random_regs();
        random_phase(300);
        drain();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
